>>> hw/rtl/utf8_to_codepoint_decoder_macros.svh
// ----------------------------------------------------------------------------
// UTF-8 decoder assertion macros
// Concurrent assertion wrappers, empty when built for synthesis.
// ----------------------------------------------------------------------------
`ifndef UTF8_TO_CODEPOINT_DECODER_MACROS_SVH
`define UTF8_TO_CODEPOINT_DECODER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define U2CP_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("u2cp assertion failed");

// Next-cycle implication.
`define U2CP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("u2cp assertion failed");

`else

`define U2CP_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define U2CP_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> hw/rtl/u2cp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2cp_pkg
// Widths, constants and the result type of the UTF-8 decoder.
// ----------------------------------------------------------------------------
package u2cp_pkg;

   localparam int BYTE_W = 8;
   localparam int CP_W   = 21;

   // Result queue depth; one request may add two results
   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CP_W-1:0] CP_REPLACEMENT = 21'h00FFFD;
   localparam logic [CP_W-1:0] CP_MAX         = 21'h10FFFF;
   localparam logic [CP_W-1:0] CP_SURR_LO     = 21'h00D800;
   localparam logic [CP_W-1:0] CP_SURR_HI     = 21'h00DFFF;
   localparam logic [CP_W-1:0] CP_MIN_LEN2    = 21'h000080;
   localparam logic [CP_W-1:0] CP_MIN_LEN3    = 21'h000800;
   localparam logic [CP_W-1:0] CP_MIN_LEN4    = 21'h010000;

   localparam logic [BYTE_W-1:0] LEAD2_LO = 8'hC2;
   localparam logic [BYTE_W-1:0] LEAD2_HI = 8'hDF;
   localparam logic [BYTE_W-1:0] LEAD3_LO = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD3_HI = 8'hEF;
   localparam logic [BYTE_W-1:0] LEAD4_LO = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD4_HI = 8'hF4;
   localparam logic [BYTE_W-1:0] ASCII_LIM = 8'h80;

   // Sequence length codes
   localparam logic [2:0] SEQ_NONE = 3'd0;
   localparam logic [2:0] SEQ_LEN2 = 3'd2;
   localparam logic [2:0] SEQ_LEN3 = 3'd3;
   localparam logic [2:0] SEQ_LEN4 = 3'd4;

   typedef struct packed {
      logic [CP_W-1:0] code_point;
      logic            is_error;
      logic            run_last;
      logic            string_last;
   } result_type;

endpackage

>>> hw/rtl/u2cp_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2cp_intf
// Valid/ready channels for raw bytes in and code points out.
// ----------------------------------------------------------------------------
interface u2cp_req_if import u2cp_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              final_byte;

   modport source (output valid, output data_byte, output final_byte, input ready);
   modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface u2cp_rsp_if import u2cp_pkg::*; ();
   logic            valid;
   logic            ready;
   logic [CP_W-1:0] code_point;
   logic            is_error;
   logic            run_last;
   logic            string_last;

   modport source (output valid, output code_point, output is_error,
                   output run_last, output string_last, input ready);
   modport sink   (input valid, input code_point, input is_error,
                   input run_last, input string_last, output ready);
endinterface

>>> hw/rtl/utf8_to_codepoint_decoder.sv
`timescale 1ns / 1ps
`include "utf8_to_codepoint_decoder_macros.svh"
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder
// Results are registered into a four-entry result queue, read from its head.
// Throughput: one request per cycle while ready; a request yields zero, one
// or two results; the queue drains a result per cycle while rsp ready is high.
// Request ready is high while the queue has room for two results.
// Reset (synchronous) empties the queue and drops any open sequence.
// ----------------------------------------------------------------------------
module utf8_to_codepoint_decoder
   import u2cp_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   u2cp_req_if.sink   req_if,
   u2cp_rsp_if.source rsp_if
);

   // Sequence state
   logic [1:0]      bytes_left_ff, bytes_left_in;
   logic [2:0]      seq_length_ff, seq_length_in;
   logic [CP_W-1:0] code_accum_ff, code_accum_in;

   // Result queue
   result_type       queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic            req_accept;
   logic            rsp_pop;
   logic            pending;
   logic            is_cont;
   logic            fin;
   logic [BYTE_W-1:0] b;
   logic [CP_W-1:0] accum_next;
   logic            bad_value;
   logic            emit_a, emit_b;
   logic [CP_W-1:0] cp_a, cp_b;
   logic            err_a, err_b;
   logic            as_lead;
   result_type      slot0, slot1;
   logic [1:0]      n_push;
   logic [PTR_W-1:0] wr_ptr_plus1;

   assign b          = req_if.data_byte;
   assign fin        = req_if.final_byte;
   assign req_accept = req_if.valid & req_if.ready;
   assign rsp_pop    = rsp_if.valid & rsp_if.ready;
   assign pending    = (bytes_left_ff != 2'd0);
   assign is_cont    = (b[7:6] == 2'b10);
   assign accum_next = {code_accum_ff[CP_W-7:0], b[5:0]};

   // Check a completed sequence for overlong, surrogate or out-of-range values
   assign bad_value = ((seq_length_ff == SEQ_LEN2) && (accum_next < CP_MIN_LEN2)) ||
                      ((seq_length_ff == SEQ_LEN3) && (accum_next < CP_MIN_LEN3)) ||
                      ((seq_length_ff == SEQ_LEN4) && (accum_next < CP_MIN_LEN4)) ||
                      ((accum_next >= CP_SURR_LO) && (accum_next <= CP_SURR_HI)) ||
                      (accum_next > CP_MAX);

   // Decode one request: result A closes the open sequence, result B the lead
   always_comb begin
      bytes_left_in = bytes_left_ff;
      seq_length_in = seq_length_ff;
      code_accum_in = code_accum_ff;
      emit_a        = 1'b0;
      cp_a          = CP_REPLACEMENT;
      err_a         = 1'b1;
      emit_b        = 1'b0;
      cp_b          = CP_REPLACEMENT;
      err_b         = 1'b1;
      as_lead       = 1'b1;

      if (pending) begin
         if (is_cont) begin
            as_lead       = 1'b0;
            code_accum_in = accum_next;
            bytes_left_in = bytes_left_ff - 2'd1;
            if (bytes_left_ff == 2'd1) begin
               emit_a = 1'b1;
               cp_a   = bad_value ? CP_REPLACEMENT : accum_next;
               err_a  = bad_value;
               bytes_left_in = 2'd0;
               seq_length_in = SEQ_NONE;
               code_accum_in = '0;
            end else if (fin) begin
               emit_a = 1'b1;
            end
         end else begin
            // drop the broken sequence, then treat this byte as a lead
            emit_a        = 1'b1;
            bytes_left_in = 2'd0;
            seq_length_in = SEQ_NONE;
            code_accum_in = '0;
         end
      end

      if (as_lead) begin
         priority if (b < ASCII_LIM) begin
            emit_b = 1'b1;
            cp_b   = {{(CP_W-BYTE_W){1'b0}}, b};
            err_b  = 1'b0;
         end else if ((b >= LEAD2_LO) && (b <= LEAD2_HI)) begin
            seq_length_in = SEQ_LEN2;
            bytes_left_in = 2'd1;
            code_accum_in = {{(CP_W-5){1'b0}}, b[4:0]};
            emit_b        = fin;
         end else if ((b >= LEAD3_LO) && (b <= LEAD3_HI)) begin
            seq_length_in = SEQ_LEN3;
            bytes_left_in = 2'd2;
            code_accum_in = {{(CP_W-4){1'b0}}, b[3:0]};
            emit_b        = fin;
         end else if ((b >= LEAD4_LO) && (b <= LEAD4_HI)) begin
            seq_length_in = SEQ_LEN4;
            bytes_left_in = 2'd3;
            code_accum_in = {{(CP_W-3){1'b0}}, b[2:0]};
            emit_b        = fin;
         end else begin
            emit_b = 1'b1;
         end
      end

      // end of string returns to the idle state
      if (fin) begin
         bytes_left_in = 2'd0;
         seq_length_in = SEQ_NONE;
         code_accum_in = '0;
      end
   end

   // Pack the results of this request into queue slots
   always_comb begin
      slot0 = '{code_point: cp_a, is_error: err_a, run_last: 1'b0, string_last: 1'b0};
      slot1 = '{code_point: cp_b, is_error: err_b, run_last: 1'b1, string_last: fin};
      if (!emit_a) begin
         slot0 = slot1;
      end else if (!emit_b) begin
         slot0.run_last    = 1'b1;
         slot0.string_last = fin;
      end
      n_push = {1'b0, emit_a} + {1'b0, emit_b};
   end

   assign wr_ptr_plus1 = wr_ptr_ff + PTR_W'(1);

   // Advance queue pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (req_accept) begin
         wr_ptr_in = wr_ptr_ff + PTR_W'(n_push);
         count_in  = count_in + CNT_W'(n_push);
      end
      if (rsp_pop) begin
         rd_ptr_in = rd_ptr_ff + PTR_W'(1);
         count_in  = count_in - CNT_W'(1);
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff <= 2'd0;
         seq_length_ff <= SEQ_NONE;
         code_accum_ff <= '0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         count_ff      <= '0;
      end else begin
         if (req_accept) begin
            bytes_left_ff <= bytes_left_in;
            seq_length_ff <= seq_length_in;
            code_accum_ff <= code_accum_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Write results into the queue
   always_ff @(posedge clock) begin
      if (req_accept && (n_push != 2'd0)) begin
         queue_ff[wr_ptr_ff] <= slot0;
      end
      if (req_accept && (n_push == 2'd2)) begin
         queue_ff[wr_ptr_plus1] <= slot1;
      end
   end

   assign req_if.ready       = (count_ff <= CNT_W'(QUEUE_DEPTH - 2));
   assign rsp_if.valid       = (count_ff != '0);
   assign rsp_if.code_point  = queue_ff[rd_ptr_ff].code_point;
   assign rsp_if.is_error    = queue_ff[rd_ptr_ff].is_error;
   assign rsp_if.run_last    = queue_ff[rd_ptr_ff].run_last;
   assign rsp_if.string_last = queue_ff[rd_ptr_ff].string_last;

   // Checks
   `U2CP_ASSERT_NOW(a_queue_bound, clock, reset, 1'b1, count_ff <= CNT_W'(QUEUE_DEPTH))
   `U2CP_ASSERT_NOW(a_seq_consistent, clock, reset, pending, seq_length_ff > {1'b0, bytes_left_ff})
   `U2CP_ASSERT_NEXT(a_final_clears, clock, reset, req_accept && fin, bytes_left_ff == 2'd0)
   `U2CP_ASSERT_NOW(a_error_value, clock, reset, rsp_if.valid && rsp_if.is_error, rsp_if.code_point == CP_REPLACEMENT)

endmodule
